/* rtl/cpr_pkg.sv */
package cpr_pkg;

	// Fixed field widths of the access and result transactions.
	localparam int ADDR_W    = 24;
	localparam int PHYS_W    = 44;
	localparam int CNT_W     = 32;
	localparam int IDENT_W   = 13;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	// Configuration register indices.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDENTITY_PAGES = 1'd1;

	// Configuration reset values.
	localparam logic [CNT_W-1:0]   PERIOD_LENGTH_RESET  = 32'd1000;
	localparam logic [IDENT_W-1:0] IDENTITY_PAGES_RESET = 13'd4096;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNMAPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

	// One page table entry as held in the table memory.
	typedef struct packed {
		logic             valid;
		logic             read_seen;
		logic [CNT_W-1:0] phys_page;
		logic [CNT_W-1:0] write_period;
		logic [CNT_W-1:0] read_period;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic update;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

/* rtl/cpr_ram.sv */
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/cpr_ctrl.sv */
module cpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  cpr_pkg::stat_t   stat,
	output cpr_pkg::cmd_t    cmd,
	output logic             in_stall
);

	cpr_pkg::state_t state_q;
	cpr_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cpr_pkg::ST_CLEAR: begin
				if (stat.clear_last) begin
					state_n = cpr_pkg::ST_IDLE;
				end
			end
			cpr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_n = cpr_pkg::ST_LOOKUP;
				end
			end
			cpr_pkg::ST_LOOKUP: begin
				if (!stat.out_busy) begin
					state_n = cpr_pkg::ST_IDLE;
				end
			end
			default: state_n = cpr_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			cpr_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			cpr_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			cpr_pkg::ST_LOOKUP: begin
				cmd.update = !stat.out_busy;
			end
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* rtl/cpr_datapath.sv */
module cpr_datapath #(
	parameter int PAGE_BITS  = 12,
	parameter int VIRT_PAGES = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cpr_pkg::cmd_t                      cmd,
	output cpr_pkg::stat_t                     stat,
	input  logic                               cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpr_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic [cpr_pkg::ADDR_W-1:0]         address,
	input  logic                               is_write,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [cpr_pkg::PHYS_W-1:0]         phys_address,
	output logic                               access_was_write,
	output logic [cpr_pkg::CNT_W-1:0]          period_number,
	output logic [cpr_pkg::STATUS_W-1:0]       status,
	output logic [cpr_pkg::CNT_W-1:0]          remap_total,
	output logic [cpr_pkg::CNT_W-1:0]          translate_total,
	output logic [cpr_pkg::CNT_W-1:0]          read_total,
	output logic [cpr_pkg::CNT_W-1:0]          write_total
);

	localparam int IDX_W   = $clog2(VIRT_PAGES);
	localparam int VPAGE_W = cpr_pkg::ADDR_W - PAGE_BITS;
	localparam int ENT_W   = $bits(cpr_pkg::entry_t);

	// Configuration registers.
	logic [cpr_pkg::CNT_W-1:0]   period_length_q;
	logic [cpr_pkg::IDENT_W-1:0] identity_pages_q;

	// Running state.
	logic [cpr_pkg::CNT_W-1:0] access_in_period_q;
	logic [cpr_pkg::CNT_W-1:0] current_period_q;
	logic [cpr_pkg::CNT_W-1:0] next_phys_q;
	logic [cpr_pkg::CNT_W-1:0] remap_q;
	logic [cpr_pkg::CNT_W-1:0] translate_q;
	logic [cpr_pkg::CNT_W-1:0] read_q;
	logic [cpr_pkg::CNT_W-1:0] write_q;
	logic [IDX_W-1:0]          clr_idx_q;

	// Transaction held between acceptance and table update.
	logic [cpr_pkg::ADDR_W-1:0] addr_q;
	logic                       wr_q;

	// Result registers.
	logic                         out_valid_q;
	logic [cpr_pkg::PHYS_W-1:0]   phys_q;
	logic                         was_write_q;
	logic [cpr_pkg::CNT_W-1:0]    period_out_q;
	logic [cpr_pkg::STATUS_W-1:0] status_q;

	logic [VPAGE_W-1:0]           vpage;
	logic [IDX_W-1:0]             idx;
	logic [IDX_W-1:0]             rd_idx;
	logic [ENT_W-1:0]             ram_rdata;
	logic [ENT_W-1:0]             ram_wdata;
	logic [IDX_W-1:0]             ram_waddr;
	cpr_pkg::entry_t              ent;
	cpr_pkg::entry_t              ent_n;
	logic                         exhausted;
	logic                         alloc;
	logic                         trans;
	logic                         have_page;
	logic [cpr_pkg::CNT_W-1:0]    ppage;
	logic [cpr_pkg::STATUS_W-1:0] status_n;
	logic [cpr_pkg::PHYS_W-1:0]   phys_n;

	assign vpage  = addr_q[cpr_pkg::ADDR_W-1:PAGE_BITS];
	assign idx    = IDX_W'(vpage);
	assign rd_idx = IDX_W'(address[cpr_pkg::ADDR_W-1:PAGE_BITS]);
	assign ent    = cpr_pkg::entry_t'(ram_rdata);

	assign ram_waddr = cmd.clear ? clr_idx_q : idx;
	assign ram_wdata = cmd.clear ? '0 : ENT_W'(ent_n);

	cpr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (VIRT_PAGES)
	) u_table (
		.clk   (clk),
		.we    (cmd.clear | cmd.update),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	assign exhausted = (next_phys_q == '1);

	// Table read-modify-write for the transaction in hand.
	always_comb begin
		ent_n     = ent;
		alloc     = 1'b0;
		trans     = 1'b0;
		have_page = 1'b1;
		status_n  = cpr_pkg::STATUS_OK;
		ppage     = ent.phys_page;
		if (ent.valid) begin
			if (wr_q && (ent.write_period != current_period_q)) begin
				if (exhausted) begin
					status_n = cpr_pkg::STATUS_EXHAUSTED;
				end else begin
					ent_n.phys_page    = next_phys_q;
					ent_n.write_period = current_period_q;
					alloc              = 1'b1;
				end
			end
			if (!wr_q && (!ent.read_seen || (ent.read_period != current_period_q))) begin
				ent_n.read_seen   = 1'b1;
				ent_n.read_period = current_period_q;
				trans             = 1'b1;
			end
			ppage = ent_n.phys_page;
		end else if (wr_q) begin
			if (exhausted) begin
				status_n  = cpr_pkg::STATUS_EXHAUSTED;
				have_page = 1'b0;
			end else begin
				ent_n.valid        = 1'b1;
				ent_n.phys_page    = next_phys_q;
				ent_n.write_period = current_period_q;
				ent_n.read_seen    = 1'b0;
				ent_n.read_period  = '0;
				alloc              = 1'b1;
				ppage              = next_phys_q;
			end
		end else begin
			if (cpr_pkg::CNT_W'(vpage) < cpr_pkg::CNT_W'(identity_pages_q)) begin
				trans = 1'b1;
				ppage = cpr_pkg::CNT_W'(vpage);
			end else begin
				status_n  = cpr_pkg::STATUS_UNMAPPED;
				have_page = 1'b0;
			end
		end
		phys_n = have_page ? cpr_pkg::PHYS_W'({ppage, addr_q[PAGE_BITS-1:0]}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_length_q    <= cpr_pkg::PERIOD_LENGTH_RESET;
			identity_pages_q   <= cpr_pkg::IDENTITY_PAGES_RESET;
			next_phys_q        <= cpr_pkg::CNT_W'(cpr_pkg::IDENTITY_PAGES_RESET);
			access_in_period_q <= '0;
			current_period_q   <= '0;
			remap_q            <= '0;
			translate_q        <= '0;
			read_q             <= '0;
			write_q            <= '0;
			clr_idx_q          <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cpr_pkg::REG_PERIOD_LENGTH: begin
						period_length_q <= cfg_data;
					end
					cpr_pkg::REG_IDENTITY_PAGES: begin
						identity_pages_q <= cfg_data[cpr_pkg::IDENT_W-1:0];
						next_phys_q      <= cpr_pkg::CNT_W'(cfg_data[cpr_pkg::IDENT_W-1:0]);
					end
					default: ;
				endcase
			end
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			// The count reaching the period length means this access opens a new period.
			if (cmd.accept) begin
				if (access_in_period_q >= period_length_q) begin
					current_period_q   <= cpr_pkg::sat_inc(current_period_q);
					access_in_period_q <= '0;
				end else begin
					access_in_period_q <= access_in_period_q + cpr_pkg::CNT_W'(1);
				end
			end
			if (cmd.update) begin
				if (alloc) begin
					next_phys_q <= next_phys_q + cpr_pkg::CNT_W'(1);
					remap_q     <= cpr_pkg::sat_inc(remap_q);
				end
				if (trans) begin
					translate_q <= cpr_pkg::sat_inc(translate_q);
				end
				if (wr_q) begin
					write_q <= cpr_pkg::sat_inc(write_q);
				end else begin
					read_q <= cpr_pkg::sat_inc(read_q);
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= address;
			wr_q   <= is_write;
		end
		if (cmd.update) begin
			phys_q       <= phys_n;
			was_write_q  <= wr_q;
			period_out_q <= current_period_q;
			status_q     <= status_n;
		end
	end

	assign stat.clear_last = (clr_idx_q == IDX_W'(VIRT_PAGES - 1));
	assign stat.out_busy   = out_valid_q & out_stall;

	assign out_valid        = out_valid_q;
	assign phys_address     = phys_q;
	assign access_was_write = was_write_q;
	assign period_number    = period_out_q;
	assign status           = status_q;
	// The counters only move on an update, which waits until the result is free.
	assign remap_total      = remap_q;
	assign translate_total  = translate_q;
	assign read_total       = read_q;
	assign write_total      = write_q;

endmodule

/* rtl/checkpoint_page_remapper_unit.sv */
// Page remapper for checkpointing: one memory access in, one translated result out.
// The access channel (in_valid, in_stall, address, is_write) carries one transaction
// per access; the result channel (out_valid, out_stall and the result fields) returns
// one transaction per access, in order. Configuration must be written by the user
// through cfg_we, cfg_index and cfg_data while the block is idle, which the block
// itself does not enforce: index 0 is the period length, index 1 the number of
// identity-mapped pages, which also restarts the allocator. The page table memory
// is read when an access is accepted and written back, with the result register
// loaded, when the update follows; the update waits while a stalled result is held.
// With no forwarding, the next access is accepted only after that write-back.
// A result becomes valid when the table update loads the result register.
// After reset the block sweeps the page table once, one entry a cycle, holding
// in_stall high; configuration writes are taken during the sweep.
// The result register frees the access side: a new access is accepted while a result
// waits. If the receiver stalls, the result holds steady and the following access
// waits with its table entry until the result has been taken.
// VIRT_PAGES must be a power of two; page numbers alias modulo VIRT_PAGES.
module checkpoint_page_remapper_unit #(
	parameter int PAGE_BITS  = 12,
	parameter int VIRT_PAGES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpr_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cpr_pkg::ADDR_W-1:0]    address,
	input  logic                          is_write,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cpr_pkg::PHYS_W-1:0]    phys_address,
	output logic                          access_was_write,
	output logic [cpr_pkg::CNT_W-1:0]     period_number,
	output logic [cpr_pkg::STATUS_W-1:0]  status,
	output logic [cpr_pkg::CNT_W-1:0]     remap_total,
	output logic [cpr_pkg::CNT_W-1:0]     translate_total,
	output logic [cpr_pkg::CNT_W-1:0]     read_total,
	output logic [cpr_pkg::CNT_W-1:0]     write_total
);

	// Commands and status between the sequencer and the datapath.
	cpr_pkg::cmd_t  cmd;
	cpr_pkg::stat_t stat;

	// The sequencer steps through the clearing sweep, acceptance and table update.
	cpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// The datapath holds the page table, the period and allocation state, the
	// counters and the result register.
	cpr_datapath #(
		.PAGE_BITS  (PAGE_BITS),
		.VIRT_PAGES (VIRT_PAGES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.address          (address),
		.is_write         (is_write),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.phys_address     (phys_address),
		.access_was_write (access_was_write),
		.period_number    (period_number),
		.status           (status),
		.remap_total      (remap_total),
		.translate_total  (translate_total),
		.read_total       (read_total),
		.write_total      (write_total)
	);

endmodule
